>>> rtl/spqr_pkg.sv
// ----------------------------------------------------------------------------
// spqr_pkg
// Shared types and constants for the sorted priority queue with remove.
// ----------------------------------------------------------------------------
package spqr_pkg;

	// Field widths of the item channels
	localparam int MODE_W   = 2;
	localparam int ID_W     = 16;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 2;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_VIEW   = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// Source of the result entry fields
	typedef logic [1:0] osrc_t;
	localparam osrc_t OSRC_ZERO = 2'd0;
	localparam osrc_t OSRC_HIT  = 2'd1;
	localparam osrc_t OSRC_RD   = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic                  start;
		logic                  add_step;
		logic                  del_step;
		logic                  view_adv;
		logic                  out_load;
		osrc_t                 out_src;
		logic [STATUS_W-1:0]   out_status;
		logic                  out_last;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic add_done;
		logic walk_last;
		logic del_hit;
	} dp_stat_t;

endpackage

>>> rtl/spqr_if.sv
// ----------------------------------------------------------------------------
// spqr_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface spqr_req_if;
	import spqr_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [ID_W-1:0]     task_id;
	logic [PRIO_W-1:0]   task_priority;

	modport source (output valid, output mode, output task_id, output task_priority,
		input ready);
	modport sink (input valid, input mode, input task_id, input task_priority,
		output ready);
endinterface

interface spqr_rsp_if;
	import spqr_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     result_id;
	logic [PRIO_W-1:0]   result_priority;
	logic                last_item;

	modport source (output valid, output status, output result_id, output result_priority,
		output last_item, input ready);
	modport sink (input valid, input status, input result_id, input result_priority,
		input last_item, output ready);
endinterface

>>> rtl/spqr_dp.sv
// ----------------------------------------------------------------------------
// spqr_dp
// Datapath: entry memory, count, walk pointer, hit capture and result register.
// ----------------------------------------------------------------------------
module spqr_dp #(
	parameter int CAPACITY       = 16,
	parameter int PRIORITY_WIDTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spqr_pkg::dp_cmd_t                cmd,
	output spqr_pkg::dp_stat_t               stat,
	input  logic [spqr_pkg::MODE_W-1:0]      in_mode,
	input  logic [spqr_pkg::ID_W-1:0]        in_task_id,
	input  logic [spqr_pkg::PRIO_W-1:0]      in_task_priority,
	output logic [spqr_pkg::STATUS_W-1:0]    status,
	output logic [spqr_pkg::ID_W-1:0]        result_id,
	output logic [spqr_pkg::PRIO_W-1:0]      result_priority,
	output logic                             last_item
);
	import spqr_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (PRIORITY_WIDTH < PRIO_W) ? PRIORITY_WIDTH : PRIO_W;

	// Entry store, slot 0 is the head
	logic [ID_W-1:0] mem_id   [CAPACITY];
	logic [SW-1:0]   mem_prio [CAPACITY];

	logic [MODE_W-1:0]   mode_q;
	logic [ID_W-1:0]     tid_q;
	logic [SW-1:0]       tprio_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       ptr_q;
	logic                found_q;
	logic [ID_W-1:0]     hit_id_q;
	logic [SW-1:0]       hit_prio_q;
	logic [ID_W-1:0]     rd_id_q;
	logic [SW-1:0]       rd_prio_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ID_W-1:0]     out_id_q;
	logic [SW-1:0]       out_prio_q;
	logic                out_last_q;

	logic            match;
	logic            walk_last;
	logic            add_done;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [ID_W-1:0] wr_id;
	logic [SW-1:0]   wr_prio;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;

	// Walk conditions on the entry just read
	assign match     = (mode_q == MODE_POP) || (rd_id_q == tid_q);
	assign walk_last = (ptr_q == count_q - CW'(1));
	assign add_done  = (ptr_q == '0) || (rd_prio_q >= tprio_q);

	assign stat.count_zero = (count_q == '0);
	assign stat.count_full = (count_q == CW'(CAPACITY));
	assign stat.add_done   = add_done;
	assign stat.walk_last  = walk_last;
	assign stat.del_hit    = found_q || match;

	// Memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(ptr_q);
		wr_id   = rd_id_q;
		wr_prio = rd_prio_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		if (cmd.start) begin
			rd_en   = 1'b1;
			rd_addr = (in_mode == MODE_ADD) ? AW'(count_q - CW'(1)) : '0;
		end
		// insert walks from the tail, moving lower entries down one slot
		if (cmd.add_step) begin
			wr_en = 1'b1;
			if (add_done) begin
				wr_id   = tid_q;
				wr_prio = tprio_q;
			end else begin
				rd_en   = 1'b1;
				rd_addr = AW'(ptr_q - CW'(2));
			end
		end
		// delete walks from the head, moving entries past the hit up one slot
		if (cmd.del_step) begin
			if (found_q) begin
				wr_en   = 1'b1;
				wr_addr = AW'(ptr_q - CW'(1));
			end
			if (!walk_last) begin
				rd_en   = 1'b1;
				rd_addr = AW'(ptr_q + CW'(1));
			end
		end
		if (cmd.view_adv) begin
			rd_en   = 1'b1;
			rd_addr = AW'(ptr_q + CW'(1));
		end
	end

	// Entry memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_id[wr_addr]   <= wr_id;
			mem_prio[wr_addr] <= wr_prio;
		end
		if (rd_en) begin
			rd_id_q   <= mem_id[rd_addr];
			rd_prio_q <= mem_prio[rd_addr];
		end
	end

	// Count, walk pointer and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				ptr_q   <= (in_mode == MODE_ADD) ? count_q : '0;
				found_q <= 1'b0;
			end
			if (cmd.add_step) begin
				if (add_done) begin
					count_q <= count_q + CW'(1);
				end else begin
					ptr_q <= ptr_q - CW'(1);
				end
			end
			if (cmd.del_step) begin
				if (!found_q && match) begin
					found_q <= 1'b1;
				end
				if (walk_last) begin
					if (found_q || match) begin
						count_q <= count_q - CW'(1);
					end
				end else begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			if (cmd.view_adv) begin
				ptr_q <= ptr_q + CW'(1);
			end
		end
	end

	// Request latch, hit capture and result register
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q  <= in_mode;
			tid_q   <= in_task_id;
			tprio_q <= in_task_priority[SW-1:0];
		end
		if (cmd.del_step && !found_q && match) begin
			hit_id_q   <= rd_id_q;
			hit_prio_q <= rd_prio_q;
		end
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
			unique case (cmd.out_src)
				OSRC_HIT: begin
					out_id_q   <= hit_id_q;
					out_prio_q <= hit_prio_q;
				end
				OSRC_RD: begin
					out_id_q   <= rd_id_q;
					out_prio_q <= rd_prio_q;
				end
				default: begin
					out_id_q   <= '0;
					out_prio_q <= '0;
				end
			endcase
		end
	end

	assign status          = out_status_q;
	assign result_id       = out_id_q;
	assign result_priority = PRIO_W'(out_prio_q);
	assign last_item       = out_last_q;

endmodule

>>> rtl/spqr_ctrl.sv
// ----------------------------------------------------------------------------
// spqr_ctrl
// Controller: sequences the insert, delete and list walks and the result slot.
// ----------------------------------------------------------------------------
module spqr_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [spqr_pkg::MODE_W-1:0]  in_mode,
	output logic                         in_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output spqr_pkg::dp_cmd_t            cmd,
	input  spqr_pkg::dp_stat_t           stat
);
	import spqr_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADD  = 3'd1;
	localparam logic [2:0] S_DEL  = 3'd2;
	localparam logic [2:0] S_VIEW = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]          state_q, state_d;
	logic [STATUS_W-1:0] resp_status_q, resp_status_d;
	osrc_t               resp_src_q, resp_src_d;
	logic                out_valid_q;
	logic                slot_free;
	logic                accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		resp_status_d = resp_status_q;
		resp_src_d    = resp_src_q;
		cmd           = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.start  = 1'b1;
					resp_src_d = OSRC_ZERO;
					unique case (in_mode)
						MODE_ADD: begin
							if (stat.count_full) begin
								resp_status_d = ST_FULL;
								state_d       = S_RESP;
							end else begin
								state_d = S_ADD;
							end
						end
						MODE_POP, MODE_REMOVE: begin
							if (stat.count_zero) begin
								resp_status_d = ST_EMPTY;
								state_d       = S_RESP;
							end else begin
								state_d = S_DEL;
							end
						end
						MODE_VIEW: begin
							if (stat.count_zero) begin
								resp_status_d = ST_EMPTY;
								state_d       = S_RESP;
							end else begin
								state_d = S_VIEW;
							end
						end
					endcase
				end
			end
			S_ADD: begin
				cmd.add_step = 1'b1;
				if (stat.add_done) begin
					resp_status_d = ST_OK;
					resp_src_d    = OSRC_ZERO;
					state_d       = S_RESP;
				end
			end
			S_DEL: begin
				cmd.del_step = 1'b1;
				if (stat.walk_last) begin
					resp_status_d = stat.del_hit ? ST_OK : ST_NOT_FOUND;
					resp_src_d    = stat.del_hit ? OSRC_HIT : OSRC_ZERO;
					state_d       = S_RESP;
				end
			end
			S_VIEW: begin
				if (slot_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_src    = OSRC_RD;
					cmd.out_status = ST_OK;
					cmd.out_last   = stat.walk_last;
					if (stat.walk_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.view_adv = 1'b1;
					end
				end
			end
			S_RESP: begin
				if (slot_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_src    = resp_src_q;
					cmd.out_status = resp_status_q;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			resp_status_q <= ST_OK;
			resp_src_q    <= OSRC_ZERO;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			resp_status_q <= resp_status_d;
			resp_src_q    <= resp_src_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/sorted_priority_queue_with_remove_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_remove_unit
// Priority queue of up to CAPACITY (id, priority) entries kept in descending
// priority order, equal priorities in arrival order. Request modes: add, pop
// head, remove first entry with a given id, and list all entries. Every request
// gives one result (list gives one per stored entry), the final one flagged by
// last_item. Entries sit in a memory with one write port and one registered
// read port, and a request walks it one slot per clock (a list walk also waits
// while the result register is still full): an add walks the entries below the
// insert point, a pop, remove or list all stored entries. Requests that find
// the queue full or empty get their error result without a walk. Requests
// are taken one at a time; a new request is accepted while the last result
// still waits in the output register. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_remove_unit #(
	parameter int CAPACITY       = 16,
	parameter int PRIORITY_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	spqr_req_if.sink    req,
	spqr_rsp_if.source  rsp
);
	import spqr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencing
	spqr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_mode   (req.mode),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Entry store and result register
	spqr_dp #(
		.CAPACITY       (CAPACITY),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_mode          (req.mode),
		.in_task_id       (req.task_id),
		.in_task_priority (req.task_priority),
		.status           (rsp.status),
		.result_id        (rsp.result_id),
		.result_priority  (rsp.result_priority),
		.last_item        (rsp.last_item)
	);

endmodule

>>> rtl/spqr_checker.sv
// ----------------------------------------------------------------------------
// spqr_checker
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spqr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [spqr_pkg::STATUS_W-1:0] rsp_status,
	input logic [spqr_pkg::ID_W-1:0]     rsp_result_id,
	input logic [spqr_pkg::PRIO_W-1:0]   rsp_result_priority,
	input logic                          rsp_last_item
);
	import spqr_pkg::*;

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_result_id) && $stable(rsp_result_priority)
			&& $stable(rsp_last_item))
		else $error("stalled result changed");

	// Error results are single, final and carry no entry
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> rsp_last_item
			&& (rsp_result_id == '0) && (rsp_result_priority == '0))
		else $error("error result with entry fields or not final");

	// One request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	// A listing streams without gaps
	a_list_stream: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last_item |=> rsp_valid)
		else $error("gap inside a multi-result response");

endmodule

bind sorted_priority_queue_with_remove_unit spqr_checker u_spqr_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_result_id       (rsp.result_id),
	.rsp_result_priority (rsp.result_priority),
	.rsp_last_item       (rsp.last_item)
);
